// File: sv/tcce_pkg.sv
// tcce_pkg: shared codes, constants and types of the text console cursor engine
// used by tcce_engine and text_console_cursor_engine_core; no dependencies
package tcce_pkg;

  // operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // control bytes and printable range
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7F;

  localparam int TAB_STOP = 8;

  // white on black space
  localparam logic [15:0] BLANK_CELL = 16'h0F20;
  localparam logic [3:0]  BG_BLACK   = 4'h0;

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_ACT    = 7'b0000100,
    ST_RDATA  = 7'b0001000,
    ST_CLEAR  = 7'b0010000,
    ST_SCROLL = 7'b0100000,
    ST_DONE   = 7'b1000000
  } tcce_state_t;

  typedef struct packed {
    logic        valid;
    logic [10:0] cursor_pos;
    logic        bell;
    logic [15:0] cell_word;
  } tcce_result_t;

  typedef struct packed {
    logic clearing;
    logic scrolling;
  } tcce_status_t;

endpackage

// File: sv/text_console_cursor_engine_core.sv
// text_console_cursor_engine_core: top level of the text console, output register and buffer
// depends on tcce_pkg, tcce_engine and tcce_ram
//
//   channel  handshake            payload
//   in       in_valid / in_ready  operation, char_code, fg_color, cell_index
//   out      out_valid / out_ready cursor_pos, bell, cell_word
//
// a put or control byte passes ST_ACT, a read ST_RDATA, each then ST_DONE; a pending wrap is resolved in ST_ACT first
// a scroll walks the buffer through one shared address counter, reading one row ahead
// clear sweeps the whole buffer, one blank cell written per cycle
// after reset the same sweep blanks the buffer with in_ready low
// one item at a time; a finished result sits in the output register while the next is taken
module text_console_cursor_engine_core
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [7:0]  char_code,
  input  logic [3:0]  fg_color,
  input  logic [10:0] cell_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] cursor_pos,
  output logic        bell,
  output logic [15:0] cell_word
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  tcce_result_t  eng_res;
  tcce_status_t  status;
  logic          res_free;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic          out_valid_next;

  assign res_free       = !out_valid || out_ready;
  assign out_valid_next = (eng_res.valid && res_free) || (out_valid && !out_ready);

  tcce_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .char_code  (char_code),
    .fg_color   (fg_color),
    .cell_index (cell_index),
    .res_free   (res_free),
    .res        (eng_res),
    .status     (status),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  tcce_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res.valid && res_free) begin
      cursor_pos <= eng_res.cursor_pos;
      bell       <= eng_res.bell;
      cell_word  <= eng_res.cell_word;
    end
  end

`ifndef SYNTHESIS
  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (status.clearing || status.scrolling) |-> !in_ready)
    else $error("transaction taken during a buffer sweep");

  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_CLEAR)) |=> !in_ready)
    else $error("clear did not start its sweep");

  a_bell_at_home: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bell) |-> (cursor_pos == 11'd0))
    else $error("bell raised away from the home position");

  a_init_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("ready before the buffer was blanked");
`endif

endmodule

// File: sv/tcce_ram.sv
// tcce_ram: generic simple dual-port RAM, one write port, one registered read port
// no dependencies
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/tcce_engine.sv
// tcce_engine: sequencer of the console, cursor registers and the buffer sweep counter
// depends on tcce_pkg; drives the ports of one tcce_ram
module tcce_engine
  import tcce_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          operation,
  input  logic [7:0]                          char_code,
  input  logic [3:0]                          fg_color,
  input  logic [10:0]                         cell_index,
  input  logic                                res_free,
  output tcce_result_t                        res,
  output tcce_status_t                        status,
  output logic                                ram_we,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_waddr,
  output logic [15:0]                         ram_wdata,
  output logic [$clog2(COLUMNS*ROWS)-1:0]     ram_raddr,
  input  logic [15:0]                         ram_rdata
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(CELLS + 1);
  localparam int PW    = $clog2(CELLS + 1);
  localparam int CLW   = $clog2(COLUMNS + 1);
  localparam int RW    = $clog2(ROWS);

  tcce_state_t    state;
  logic [CW-1:0]  cnt;
  logic           scr_valid;
  logic [AW-1:0]  scr_addr;
  logic           resume_act;
  logic [CLW-1:0] col;
  logic [RW-1:0]  row;
  logic [7:0]     ch_q;
  logic [3:0]     fg_q;
  logic           rd_hit;
  logic           res_bell;
  logic [15:0]    res_word;

  logic            accept;
  logic            wrap_pending;
  logic            last_row;
  logic            printable;
  logic [PW-1:0]   pos;
  logic [PW+10:0]  pos_ext;
  logic [CLW:0]    tab_sum;
  logic [CLW:0]    tab_round;
  logic [CLW-1:0]  tab_col;
  logic [CW:0]     scr_rd;
  logic            index_hit;

  assign in_ready = (state == ST_IDLE) || ((state == ST_DONE) && res_free);
  assign accept   = in_valid && in_ready;

  assign wrap_pending = (col == CLW'(COLUMNS));
  assign last_row     = (row == RW'(ROWS - 1));
  assign printable    = (ch_q >= CH_PRINT_LO) && (ch_q <= CH_PRINT_HI);

  // the one multiply-add: write address while putting, cursor position when reporting
  assign pos     = PW'(row) * PW'(COLUMNS) + PW'(col);
  assign pos_ext = (PW + 11)'(pos);

  assign tab_sum   = {1'b0, col} + (CLW + 1)'(TAB_STOP);
  assign tab_round = tab_sum & ~(CLW + 1)'(TAB_STOP - 1);
  assign tab_col   = (tab_round > (CLW + 1)'(COLUMNS)) ? CLW'(COLUMNS) : tab_round[CLW-1:0];

  // scroll reads one row ahead of the write pointer
  assign scr_rd    = {1'b0, cnt} + (CW + 1)'(COLUMNS);
  assign index_hit = (CW + 11)'(cell_index) < (CW + 11)'(CELLS);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cnt        <= '0;
      scr_valid  <= 1'b0;
      resume_act <= 1'b0;
      col        <= '0;
      row        <= '0;
    end else if (accept) begin
      case (operation)
        OP_PUT:  state <= ST_ACT;
        OP_READ: state <= ST_RDATA;
        OP_CLEAR: begin
          state <= ST_CLEAR;
          cnt   <= '0;
          col   <= '0;
          row   <= '0;
        end
        default: state <= ST_DONE;
      endcase
    end else begin
      case (state)
        ST_INIT, ST_CLEAR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(CELLS - 1)) begin
            state <= (state == ST_INIT) ? ST_IDLE : ST_DONE;
          end
        end
        ST_ACT: begin
          if (wrap_pending) begin
            col <= '0;
            if (last_row) begin
              resume_act <= 1'b1;
              cnt        <= '0;
              scr_valid  <= 1'b0;
              state      <= ST_SCROLL;
            end else begin
              row <= row + RW'(1);
            end
          end else begin
            state <= ST_DONE;
            case (ch_q)
              CH_BS: begin
                if (col != '0) begin
                  col <= col - CLW'(1);
                end else if (row != '0) begin
                  row <= row - RW'(1);
                  col <= CLW'(COLUMNS - 1);
                end
              end
              CH_TAB: col <= tab_col;
              CH_CR:  col <= '0;
              CH_LF: begin
                col <= '0;
                if (last_row) begin
                  resume_act <= 1'b0;
                  cnt        <= '0;
                  scr_valid  <= 1'b0;
                  state      <= ST_SCROLL;
                end else begin
                  row <= row + RW'(1);
                end
              end
              default: begin
                if (printable) begin
                  col <= col + CLW'(1);
                end
              end
            endcase
          end
        end
        ST_SCROLL: begin
          if (cnt != CW'(CELLS)) begin
            cnt       <= cnt + CW'(1);
            scr_valid <= 1'b1;
          end else begin
            scr_valid <= 1'b0;
          end
          // the cursor row stays on the last row across the scroll
          if (scr_valid && (scr_addr == AW'(CELLS - 1))) begin
            state <= resume_act ? ST_ACT : ST_DONE;
          end
        end
        ST_RDATA: state <= ST_DONE;
        ST_DONE: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    scr_addr <= cnt[AW-1:0];
    if (accept) begin
      ch_q     <= char_code;
      fg_q     <= fg_color;
      rd_hit   <= index_hit;
      res_bell <= 1'b0;
      res_word <= '0;
    end else if (state == ST_RDATA) begin
      res_word <= rd_hit ? ram_rdata : '0;
    end else if ((state == ST_ACT) && !wrap_pending && (ch_q == CH_BS) &&
                 (col == '0) && (row == '0)) begin
      res_bell <= 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cnt[AW-1:0];
    ram_wdata = BLANK_CELL;
    case (state)
      ST_INIT, ST_CLEAR: ram_we = 1'b1;
      ST_SCROLL: begin
        ram_we    = scr_valid;
        ram_waddr = scr_addr;
        ram_wdata = (scr_addr < AW'(CELLS - COLUMNS)) ? ram_rdata : BLANK_CELL;
      end
      ST_ACT: begin
        ram_we    = !wrap_pending && printable;
        ram_waddr = pos[AW-1:0];
        ram_wdata = {BG_BLACK, fg_q, ch_q};
      end
      default: ;
    endcase
  end

  always_comb begin
    if (state == ST_SCROLL) begin
      ram_raddr = (scr_rd < (CW + 1)'(CELLS)) ? AW'(scr_rd) : '0;
    end else begin
      ram_raddr = index_hit ? AW'(cell_index) : '0;
    end
  end

  assign res.valid      = (state == ST_DONE);
  assign res.cursor_pos = pos_ext[10:0];
  assign res.bell       = res_bell;
  assign res.cell_word  = res_word;

  assign status.clearing  = (state == ST_INIT) || (state == ST_CLEAR);
  assign status.scrolling = (state == ST_SCROLL);

endmodule
